// File: sv/ket_pkg.sv
// Package for the keyed entry table: sizes, operation codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
package ket_pkg;

  localparam int CAPACITY  = 128;
  localparam int FUNC_W    = 2;
  localparam int KEY_W     = 32;
  localparam int HANDLE_W  = 16;
  localparam int POS_W     = 8;
  localparam int OUT_CNT_W = 8;
  localparam int ENTRY_W   = KEY_W + HANDLE_W;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_REMOVE = 2'd3
  } ket_func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic wr_ins;     // append the captured entry, count up
    logic rd_pos;     // read the slot chosen by position
    logic scan_init;  // restart the key scan
    logic scan;       // issue the next scan read, compare the previous one
    logic slot_load;  // remember the slot that matched
    logic rd_last;    // read the last entry
    logic wr_move;    // move the last entry into the remembered slot, count down
    logic res_set;    // set the pending result
    logic res_ok;
    logic res_take;   // result handle from the read data, else zero
    logic out_load;   // move the pending result into the output register
  } ket_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    ket_func_t func;
    logic      full;
    logic      pos_ok;
    logic      match;
    logic      scan_end;
  } ket_sts_t;

endpackage

// File: sv/ket_if.sv
// Channel interfaces of the keyed entry table: request and result words
// with a valid/ready handshake. Depends on ket_pkg.
interface ket_in_if import ket_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic signed [KEY_W-1:0] search_key;
  logic [HANDLE_W-1:0] entry_handle;
  logic [POS_W-1:0]    position;

  modport source (output valid, func, search_key, entry_handle, position, input ready);
  modport sink (input valid, func, search_key, entry_handle, position, output ready);
endinterface

interface ket_out_if import ket_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [HANDLE_W-1:0]  found_handle;
  logic [OUT_CNT_W-1:0] count_after;

  modport source (output valid, ok, found_handle, count_after, input ready);
  modport sink (input valid, ok, found_handle, count_after, output ready);
endinterface

// File: sv/ket_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ket_dp.sv
// Datapath of the keyed entry table: entry RAM, entry count, scan pointers
// and result registers. Depends on ket_pkg and ket_ram.
module ket_dp import ket_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ket_cmd_t             cmd,
  output ket_sts_t             sts,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [HANDLE_W-1:0]  in_handle,
  input  logic [POS_W-1:0]     in_pos,
  output logic                 out_ok,
  output logic [HANDLE_W-1:0]  out_handle,
  output logic [OUT_CNT_W-1:0] out_count
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  ket_func_t           func_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    issue_idx_r, issue_idx_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]    slot_r;
  logic                res_ok_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic                out_ok_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;
  logic                issue_more;

  assign rd_key    = ram_rdata[ENTRY_W-1:HANDLE_W];
  assign rd_handle = ram_rdata[HANDLE_W-1:0];
  assign issue_more = issue_idx_r < count_r;

  ket_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port steering.
  always_comb begin
    ram_we    = cmd.wr_ins | cmd.wr_move;
    ram_waddr = cmd.wr_move ? slot_r : IDX_W'(count_r);
    ram_wdata = cmd.wr_move ? ram_rdata : {key_r, handle_r};
    ram_raddr = IDX_W'(issue_idx_r);
    if (cmd.rd_pos) begin
      ram_raddr = IDX_W'(pos_r - POS_W'(1));
    end else if (cmd.rd_last) begin
      ram_raddr = IDX_W'(count_r - CNT_W'(1));
    end
  end

  always_comb begin
    count_nxt     = count_r;
    issue_idx_nxt = issue_idx_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    if (cmd.wr_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.wr_move) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.scan_init) begin
      issue_idx_nxt = '0;
      cmp_v_nxt     = 1'b0;
    end else if (cmd.scan) begin
      cmp_v_nxt   = issue_more;
      cmp_idx_nxt = IDX_W'(issue_idx_r);
      if (issue_more) begin
        issue_idx_nxt = issue_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      issue_idx_r <= '0;
      cmp_v_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      issue_idx_r <= issue_idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    if (cmd.load) begin
      func_r   <= ket_func_t'(in_func);
      key_r    <= in_key;
      handle_r <= in_handle;
      pos_r    <= in_pos;
    end
    if (cmd.slot_load) begin
      slot_r <= cmp_idx_r;
    end
    if (cmd.res_set) begin
      res_ok_r     <= cmd.res_ok;
      res_handle_r <= cmd.res_take ? rd_handle : '0;
    end
    if (cmd.out_load) begin
      out_ok_r     <= res_ok_r;
      out_handle_r <= res_handle_r;
      out_count_r  <= OUT_CNT_W'(count_r);
    end
  end

  always_comb begin
    sts.func     = func_r;
    sts.full     = count_r == CNT_W'(CAPACITY);
    sts.pos_ok   = (pos_r != '0) && (CMP_W'(pos_r) <= CMP_W'(count_r));
    sts.match    = cmp_v_r && (rd_key == key_r);
    sts.scan_end = !cmp_v_r && !issue_more;
  end

  assign out_ok     = out_ok_r;
  assign out_handle = out_handle_r;
  assign out_count  = out_count_r;

endmodule

// File: sv/ket_ctrl.sv
// Controller of the keyed entry table: sequences one operation at a time
// and owns the input and output handshakes. Depends on ket_pkg.
module ket_ctrl import ket_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ket_cmd_t cmd,
  input  ket_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RD_WAIT,
    ST_RM_RD,
    ST_RM_WR,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.func)
          FUNC_INSERT: begin
            cmd.wr_ins  = !sts.full;
            cmd.res_set = 1'b1;
            cmd.res_ok  = !sts.full;
            state_nxt   = ST_FIN;
          end
          FUNC_READ: begin
            if (sts.pos_ok) begin
              cmd.rd_pos = 1'b1;
              state_nxt  = ST_RD_WAIT;
            end else begin
              cmd.res_set = 1'b1;
              state_nxt   = ST_FIN;
            end
          end
          default: begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          cmd.res_set   = 1'b1;
          cmd.res_ok    = 1'b1;
          cmd.res_take  = 1'b1;
          cmd.slot_load = 1'b1;
          state_nxt     = (sts.func == FUNC_REMOVE) ? ST_RM_RD : ST_FIN;
        end else if (sts.scan_end) begin
          cmd.res_set = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_RD_WAIT: begin
        cmd.res_set  = 1'b1;
        cmd.res_ok   = 1'b1;
        cmd.res_take = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_RM_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = ST_RM_WR;
      end
      ST_RM_WR: begin
        cmd.wr_move = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/keyed_entry_table.sv
// Keyed entry table: a bounded, unordered list of up to CAPACITY entries, each a
// 32-bit key and a 16-bit handle, held in one RAM. A request word selects insert
// (append at the end, refused when full), find by key (first match from slot
// zero upward), read by one-based position, or remove by key (first match is
// returned, the last entry moves into its slot and the count drops by one).
// Every request gives exactly one result word carrying ok, the handle (zero on
// insert and on any failure) and the entry count after the operation. One
// request is worked on at a time. Insert is settled at once from the count,
// read by position reads the chosen slot, and find and remove compare the
// entries one by one from slot zero upward; a remove that hits then reads the
// last entry and moves it into the matched slot before giving its result. The
// scan speed is set by the single read port of the entry RAM, which delivers
// one entry per cycle. The RAM needs no clearing after reset, since only data
// from slots below the count is ever used. A finished result waits in an
// output register, so the next request word is taken while the previous result
// is still waiting to be taken; the result of that next word is held back until
// the output register is free.
// Depends on ket_pkg, ket_if, ket_ram, ket_dp and ket_ctrl.
module keyed_entry_table import ket_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ket_in_if.sink    in_ch,
  ket_out_if.source out_ch
);

  ket_cmd_t cmd;
  ket_sts_t sts;

  ket_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ket_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_ch.func),
    .in_key     (in_ch.search_key),
    .in_handle  (in_ch.entry_handle),
    .in_pos     (in_ch.position),
    .out_ok     (out_ch.ok),
    .out_handle (out_ch.found_handle),
    .out_count  (out_ch.count_after)
  );

  // A failed operation never reports a handle.
  a_fail_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.ok || (out_ch.found_handle == '0)))
    else $error("failed result carries a non-zero handle");

  // Once a request word is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted on consecutive cycles");

  // The reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((CAPACITY > 255) || (out_ch.count_after <= OUT_CNT_W'(CAPACITY))))
    else $error("count after operation exceeds capacity");

  // An entry move always follows a read of the last entry, which comes only after a scan hit.
  a_move_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_move |-> $past(cmd.rd_last))
    else $error("entry move without a preceding read of the last entry");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_entry_table: random and directed request words,
// a cycle-free model of the table that predicts every result word, randomised stalls.
// Depends on ket_pkg, ket_if and the keyed_entry_table RTL.
module tb_top;
  import ket_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 8;
  // Longest legal quiet spell is the deliberate receiver hold-off plus one full
  // scan of the table, so a spell that reaches this limit can only mean a hang.
  localparam int STALL_LIMIT     = 2000;
  localparam int PRESSURE_CYCLES = 250;
  localparam int PRESSURE_AFTER  = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int PCT             = 100;

  typedef struct {
    ket_func_t            op;
    logic [KEY_W-1:0]     key;
    logic [HANDLE_W-1:0]  hdl;
    logic [POS_W-1:0]     pos;
  } request_t;

  typedef struct {
    logic                 ok;
    logic [HANDLE_W-1:0]  handle;
    logic [OUT_CNT_W-1:0] count_after;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  ket_in_if  in_ch ();
  ket_out_if out_ch ();

  keyed_entry_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the table. Only slots below held_count are ever looked at,
  // which mirrors the block, where data from unwritten slots is never used.
  logic [KEY_W-1:0]    shadow_keys    [CAPACITY];
  logic [HANDLE_W-1:0] shadow_handles [CAPACITY];
  int                  held_count = 0;

  request_t            pending_requests [$];
  reply_t              expected_replies [$];
  logic [KEY_W-1:0]    key_pool [KEY_POOL_SIZE];

  int   total_requests    = 0;
  int   requests_accepted = 0;
  int   results_taken     = 0;
  int   fail_count        = 0;
  int   quiet_cycles      = 0;
  int   in_gap            = 0;
  int   out_gap           = 0;
  logic in_word_taken     = 1'b0;
  logic rx_hold_off       = 1'b0;

  // First slot whose key matches, or held_count when there is none.
  function automatic int first_slot_of(logic [KEY_W-1:0] key);
    int slot;
    slot = 0;
    while (slot < held_count && shadow_keys[slot] != key) slot++;
    return slot;
  endfunction

  // Applies one request to the shadow table and returns the result word that
  // the block must give for it.
  function automatic reply_t table_apply(ket_func_t op, logic [KEY_W-1:0] key,
                                         logic [HANDLE_W-1:0] hdl,
                                         logic [POS_W-1:0] pos);
    reply_t r;
    int     slot;
    r.ok     = 1'b0;
    r.handle = '0;
    case (op)
      FUNC_INSERT: begin
        // A full table refuses the word and stays as it is.
        if (held_count < CAPACITY) begin
          shadow_keys[held_count]    = key;
          shadow_handles[held_count] = hdl;
          held_count++;
          r.ok = 1'b1;
        end
      end
      FUNC_FIND: begin
        slot = first_slot_of(key);
        if (slot < held_count) begin
          r.ok     = 1'b1;
          r.handle = shadow_handles[slot];
        end
      end
      FUNC_READ: begin
        // Positions are one-based; zero and anything past the count fail.
        if (pos != 0 && int'(pos) <= held_count) begin
          r.ok     = 1'b1;
          r.handle = shadow_handles[int'(pos) - 1];
        end
      end
      FUNC_REMOVE: begin
        // The last entry fills the hole, so the table stays packed.
        slot = first_slot_of(key);
        if (slot < held_count) begin
          r.ok                 = 1'b1;
          r.handle             = shadow_handles[slot];
          shadow_keys[slot]    = shadow_keys[held_count - 1];
          shadow_handles[slot] = shadow_handles[held_count - 1];
          held_count--;
        end
      end
    endcase
    r.count_after = OUT_CNT_W'(held_count);
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  function automatic void queue_request(ket_func_t op, logic [KEY_W-1:0] key,
                                        logic [HANDLE_W-1:0] hdl, logic [POS_W-1:0] pos);
    request_t r;
    r.op  = op;
    r.key = key;
    r.hdl = hdl;
    r.pos = pos;
    pending_requests.push_back(r);
  endfunction

  // Random request with a given share of inserts and removes; the rest is
  // split between finds and reads. Most keys come from a small pool so that
  // finds and removes hit, and duplicates pile up.
  function automatic void queue_random_request(int insert_pct, int remove_pct);
    int                  roll;
    ket_func_t           op;
    logic [KEY_W-1:0]    key;
    logic [POS_W-1:0]    pos;
    roll = $urandom_range(0, PCT - 1);
    if (roll < insert_pct)
      op = FUNC_INSERT;
    else if (roll < insert_pct + remove_pct)
      op = FUNC_REMOVE;
    else if (roll[0])
      op = FUNC_FIND;
    else
      op = FUNC_READ;
    if ($urandom_range(0, PCT - 1) < 80)
      key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    else
      key = $urandom;
    // Positions mostly near the live range, sometimes anywhere in the field.
    if ($urandom_range(0, 9) < 7)
      pos = POS_W'($urandom_range(0, CAPACITY + 2));
    else
      pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    queue_request(op, key, HANDLE_W'($urandom), pos);
  endfunction

  // Request driver: words change on the falling edge. A word is held until it
  // has been taken, then the sender may idle for a drawn number of cycles.
  always @(negedge clk) begin : drive_requests
    request_t next_req;
    if (rst_n && (!in_ch.valid || in_word_taken)) begin
      in_word_taken = 1'b0;
      if (in_gap > 0 || pending_requests.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        next_req = pending_requests.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.func         <= next_req.op;
        in_ch.search_key   <= next_req.key;
        in_ch.entry_handle <= next_req.hdl;
        in_ch.position     <= next_req.pos;
      end
    end
  end

  // Result receiver: once a result word shows up it may be left waiting for a
  // drawn number of cycles; during the pressure spell it is not taken at all.
  always @(negedge clk) begin : drive_result_ready
    if (!rst_n || rx_hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor on the rising edge: checks taken result words against the oldest
  // prediction, predicts each accepted request word, and watches for a hang.
  always @(posedge clk) begin : observe
    reply_t want;
    logic   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        results_taken++;
        // The third hundred of every five hundred results is taken without stalls.
        out_gap = ((results_taken / 100) % 5 == 2) ? 0 : $urandom_range(0, 3);
        if (expected_replies.size() == 0) begin
          flag_mismatch("result word arrived with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (out_ch.ok !== want.ok)
            flag_mismatch($sformatf("ok: got %b, wanted %b", out_ch.ok, want.ok));
          if (out_ch.found_handle !== want.handle)
            flag_mismatch($sformatf("found_handle: got %h, wanted %h",
                                    out_ch.found_handle, want.handle));
          if (out_ch.count_after !== want.count_after)
            flag_mismatch($sformatf("count_after: got %0d, wanted %0d",
                                    out_ch.count_after, want.count_after));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        expected_replies.push_back(table_apply(ket_func_t'(in_ch.func), in_ch.search_key,
                                               in_ch.entry_handle, in_ch.position));
        requests_accepted++;
        in_word_taken = 1'b1;
        // Every fourth hundred of requests is sent back to back.
        in_gap = ((requests_accepted / 100) % 4 == 3) ? 0 : $urandom_range(0, 3);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Pressure: once traffic is flowing, stop taking results for a long spell
  // while the sender keeps offering, so the block backs up and refuses input.
  initial begin : hold_off_results
    while (results_taken < PRESSURE_AFTER) @(posedge clk);
    rx_hold_off = 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    rx_hold_off = 1'b0;
  end

  initial begin : run_control
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_INSERT;
    in_ch.search_key   = '0;
    in_ch.entry_handle = '0;
    in_ch.position     = '0;
    out_ch.ready       = 1'b0;

    // The extremes of the key range are always in the pool.
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed opening: failures on an empty table, extreme keys and handles,
    // a duplicate key, every kind of bad position, and removes that move the
    // last entry into the hole, down to an empty table again.
    queue_request(FUNC_REMOVE, 32'h0000_0000, 16'h0000, 8'd0);
    queue_request(FUNC_FIND,   32'hFFFF_FFFF, 16'h0000, 8'd0);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd0);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd1);
    queue_request(FUNC_INSERT, 32'h8000_0000, 16'hFFFF, 8'd0);
    queue_request(FUNC_INSERT, 32'h7FFF_FFFF, 16'h0000, 8'd255);
    queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 16'h1234, 8'd0);
    queue_request(FUNC_INSERT, 32'h0000_0000, 16'hABCD, 8'd0);
    queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 16'h5555, 8'd0);
    queue_request(FUNC_FIND,   32'hFFFF_FFFF, 16'h0000, 8'd0);
    queue_request(FUNC_FIND,   32'h1234_5678, 16'h0000, 8'd0);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd1);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd5);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd6);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd255);
    queue_request(FUNC_READ,   32'hFFFF_FFFF, 16'hFFFF, 8'd0);
    queue_request(FUNC_REMOVE, 32'h8000_0000, 16'h0000, 8'd0);
    queue_request(FUNC_READ,   32'h0000_0000, 16'h0000, 8'd1);
    queue_request(FUNC_FIND,   32'hFFFF_FFFF, 16'h0000, 8'd0);
    queue_request(FUNC_REMOVE, 32'h0000_0000, 16'h0000, 8'd0);
    queue_request(FUNC_REMOVE, 32'h7FFF_FFFF, 16'h0000, 8'd0);
    queue_request(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0000, 8'd0);
    queue_request(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0000, 8'd0);
    queue_request(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0000, 8'd0);

    // Random rounds: an insert-heavy stretch takes the table past full, a
    // mixed stretch works on a crowded table, a remove-heavy stretch drains
    // it, and another mixed stretch runs near empty.
    for (int round = 0; round < 2; round++) begin
      for (int i = 0; i < 160; i++) queue_random_request(85, 5);
      for (int i = 0; i < 120; i++) queue_random_request(25, 25);
      for (int i = 0; i < 160; i++) queue_random_request(5, 75);
      for (int i = 0; i < 120; i++) queue_random_request(25, 25);
    end
    total_requests = pending_requests.size();

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (requests_accepted < total_requests) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
